// ===== rtl/core/hrlp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrlp_pkg
// Types, character codes and the hex digit decoder for the hex record line
// parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_SKIP  = 8'h48;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] COUNT_MAX = 8'hff;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_CHECK  = 2'd2,
        PH_SKIP   = 2'd3
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    // Lowercase hex only; uppercase counts as a bad character.
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t       h;
        logic [7:0] d;
        h = '0;
        d = '0;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            d     = c - CH_ZERO;
            h.ok  = 1'b1;
            h.val = d[3:0];
        end else if (c inside {[CH_LA:CH_LF_HEX]}) begin
            d     = c - CH_LA + 8'd10;
            h.ok  = 1'b1;
            h.val = d[3:0];
        end
        return h;
    endfunction

endpackage

// ===== rtl/core/hex_record_line_parser_top.sv =====
// ----------------------------------------------------------------------------
// hex_record_line_parser_top
// Parses ASCII hex record lines one character at a time, reports each data
// byte and, at line feed, the address, byte count and XOR checksum result.
// ----------------------------------------------------------------------------
// An accepted character passes through the input register, then the result
// register. Throughput: one character per cycle; the input stalls only while a
// held result is stalled and the input register is full.
// Reset (rst_n low, asynchronous): pipeline empty, parser back in the header
// phase with all accumulators cleared.
module hex_record_line_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  byte_value,
    output logic [7:0]  byte_index,
    output logic [15:0] record_address,
    output logic [7:0]  received_check,
    output logic [7:0]  computed_check,
    output logic        check_ok,
    output logic        bad_char
);
    import hrlp_pkg::*;

    // input register
    logic        in_full_reg;
    logic [7:0]  char_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  hold_reg, hold_next;
    logic [1:0]  ncount_reg, ncount_next;
    logic [7:0]  bcount_reg, bcount_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  check_reg, check_next;
    logic        err_reg, err_next;

    // result register
    logic        out_valid_reg;
    logic        kind_reg;
    logic [7:0]  value_reg;
    logic [7:0]  index_reg;
    logic [15:0] raddr_reg;
    logic [7:0]  rcheck_reg;
    logic [7:0]  ccheck_reg;
    logic        ok_reg;
    logic        bad_reg;

    logic        emit;
    logic        emit_kind;
    logic [7:0]  shifted;
    logic [2:0]  ncount_inc;
    logic        advance;
    logic        work;
    hex_t        hx;

    assign advance  = !out_valid_reg || !out_stall;
    assign work     = in_full_reg && advance;
    assign in_stall = in_full_reg && !advance;

    assign hx         = hex_decode(char_reg);
    assign shifted    = {hold_reg[3:0], hx.val};
    assign ncount_inc = {1'b0, ncount_reg} + 3'd1;

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        addr_next   = addr_reg;
        hold_next   = hold_reg;
        ncount_next = ncount_reg;
        bcount_next = bcount_reg;
        xor_next    = xor_reg;
        check_next  = check_reg;
        err_next    = err_reg;
        if (char_reg == CH_LF)
        begin
            phase_next  = PH_HEADER;
            addr_next   = '0;
            hold_next   = '0;
            ncount_next = '0;
            bcount_next = '0;
            xor_next    = '0;
            check_next  = '0;
            err_next    = 1'b0;
        end
        else if (char_reg != CH_CR)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (char_reg == CH_COLON)
                        phase_next = PH_DATA;
                    else if (char_reg != CH_SKIP)
                    begin
                        if (!hx.ok)
                        begin
                            err_next   = 1'b1;
                            phase_next = PH_SKIP;
                        end
                        else
                            addr_next = {addr_reg[11:0], hx.val};
                    end
                end
                PH_DATA:
                begin
                    if (char_reg == CH_COMMA)
                        phase_next = PH_CHECK;
                    else if (!hx.ok)
                    begin
                        err_next   = 1'b1;
                        phase_next = PH_SKIP;
                    end
                    else if (ncount_inc >= 3'd2)
                    begin
                        // byte complete: fold into checksum and clear the pair
                        xor_next    = xor_reg ^ shifted;
                        hold_next   = '0;
                        ncount_next = '0;
                        if (bcount_reg != COUNT_MAX)
                            bcount_next = bcount_reg + 8'd1;
                    end
                    else
                    begin
                        hold_next   = shifted;
                        ncount_next = ncount_inc[1:0];
                    end
                end
                PH_CHECK:
                begin
                    if (!hx.ok)
                    begin
                        err_next   = 1'b1;
                        phase_next = PH_SKIP;
                    end
                    else if (ncount_reg < 2'd2)
                    begin
                        hold_next   = shifted;
                        ncount_next = ncount_inc[1:0];
                        if (ncount_inc == 3'd2)
                            check_next = shifted;
                    end
                end
                default:
                begin
                    phase_next = PH_SKIP;
                end
            endcase
        end
    end

    // result decode
    always_comb
    begin
        emit      = 1'b0;
        emit_kind = KIND_BYTE;
        if (char_reg == CH_LF)
        begin
            emit      = 1'b1;
            emit_kind = KIND_END;
        end
        else if (char_reg != CH_CR && phase_reg == PH_DATA &&
                 char_reg != CH_COMMA && hx.ok && ncount_inc >= 3'd2)
        begin
            emit = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HEADER;
            addr_reg      <= '0;
            hold_reg      <= '0;
            ncount_reg    <= '0;
            bcount_reg    <= '0;
            xor_reg       <= '0;
            check_reg     <= '0;
            err_reg       <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_full_reg <= in_valid;
            if (advance)
                out_valid_reg <= work && emit;
            if (work)
            begin
                phase_reg  <= phase_next;
                addr_reg   <= addr_next;
                hold_reg   <= hold_next;
                ncount_reg <= ncount_next;
                bcount_reg <= bcount_next;
                xor_reg    <= xor_next;
                check_reg  <= check_next;
                err_reg    <= err_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            char_reg <= char_in;
        if (work && emit)
        begin
            kind_reg <= emit_kind;
            if (emit_kind == KIND_END)
            begin
                value_reg  <= '0;
                index_reg  <= bcount_reg;
                raddr_reg  <= addr_reg;
                rcheck_reg <= check_reg;
                ccheck_reg <= xor_reg;
                ok_reg     <= (check_reg == xor_reg);
                bad_reg    <= err_reg;
            end
            else
            begin
                value_reg  <= shifted;
                index_reg  <= bcount_reg;
                raddr_reg  <= '0;
                rcheck_reg <= '0;
                ccheck_reg <= '0;
                ok_reg     <= 1'b0;
                bad_reg    <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign byte_value     = value_reg;
    assign byte_index     = index_reg;
    assign record_address = raddr_reg;
    assign received_check = rcheck_reg;
    assign computed_check = ccheck_reg;
    assign check_ok       = ok_reg;
    assign bad_char       = bad_reg;

endmodule

// ===== dv/hex_record_line_parser_checker.sv =====
// ----------------------------------------------------------------------------
// hex_record_line_parser_checker
// Watches both channels of the hex record line parser. Each accepted
// character runs through a local parser that works out the byte or
// end-of-line report it should cause. Each accepted report is compared,
// field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module hex_record_line_parser_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  char_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        kind,
    input  logic [7:0]  byte_value,
    input  logic [7:0]  byte_index,
    input  logic [15:0] record_address,
    input  logic [7:0]  received_check,
    input  logic [7:0]  computed_check,
    input  logic        check_ok,
    input  logic        bad_char,
    output int          reports_due,
    output int          fail_count
);
    import hrlp_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [7:0]  value;
        logic [7:0]  index;
        logic [15:0] address;
        logic [7:0]  rx_sum;
        logic [7:0]  calc_sum;
        logic        sum_ok;
        logic        bad;
    } line_report_t;

    line_report_t predicted_reports[$];
    int           mismatches = 0;

    // Local copy of the parser state
    phase_t       line_phase;
    logic [15:0]  addr_sum;
    logic [7:0]   pending_nibbles;
    logic [1:0]   digit_cnt;
    logic [7:0]   bytes_seen;
    logic [7:0]   data_xor;
    logic [7:0]   sum_byte;
    logic         saw_bad;

    function automatic void clear_line();
        line_phase      = PH_HEADER;
        addr_sum        = '0;
        pending_nibbles = '0;
        digit_cnt       = '0;
        bytes_seen      = '0;
        data_xor        = '0;
        sum_byte        = '0;
        saw_bad         = 1'b0;
    endfunction

    // Lowercase digits only
    function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] nib);
        nib = '0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            nib = 4'(c - CH_ZERO);
            return 1'b1;
        end
        if (c >= CH_LA && c <= CH_LF_HEX)
        begin
            nib = 4'(c - CH_LA + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit parse_char(input logic [7:0] c, output line_report_t rep);
        logic [3:0] nib;
        bit         is_hex;
        rep    = '0;
        is_hex = hex_nibble(c, nib);
        if (c == CH_CR)
            return 1'b0;
        if (c == CH_LF)
        begin
            rep.kind     = KIND_END;
            rep.index    = bytes_seen;
            rep.address  = addr_sum;
            rep.rx_sum   = sum_byte;
            rep.calc_sum = data_xor;
            rep.sum_ok   = (sum_byte == data_xor);
            rep.bad      = saw_bad;
            clear_line();
            return 1'b1;
        end
        case (line_phase)
            PH_HEADER:
            begin
                if (c == CH_COLON)
                    line_phase = PH_DATA;
                else if (c != CH_SKIP)
                begin
                    if (is_hex)
                        addr_sum = {addr_sum[11:0], nib};
                    else
                    begin
                        saw_bad    = 1'b1;
                        line_phase = PH_SKIP;
                    end
                end
            end
            PH_DATA:
            begin
                if (c == CH_COMMA)
                    line_phase = PH_CHECK;
                else if (!is_hex)
                begin
                    saw_bad    = 1'b1;
                    line_phase = PH_SKIP;
                end
                else
                begin
                    pending_nibbles = {pending_nibbles[3:0], nib};
                    digit_cnt       = digit_cnt + 2'd1;
                    if (digit_cnt == 2'd2)
                    begin
                        rep.kind  = KIND_BYTE;
                        rep.value = pending_nibbles;
                        rep.index = bytes_seen;
                        data_xor  = data_xor ^ pending_nibbles;
                        if (bytes_seen != COUNT_MAX)
                            bytes_seen = bytes_seen + 8'd1;
                        pending_nibbles = '0;
                        digit_cnt       = '0;
                        return 1'b1;
                    end
                end
            end
            PH_CHECK:
            begin
                if (!is_hex)
                begin
                    saw_bad    = 1'b1;
                    line_phase = PH_SKIP;
                end
                else if (digit_cnt != 2'd2)
                begin
                    // a nibble left over from odd data joins the checksum
                    pending_nibbles = {pending_nibbles[3:0], nib};
                    digit_cnt       = digit_cnt + 2'd1;
                    if (digit_cnt == 2'd2)
                        sum_byte = pending_nibbles;
                end
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_report_t want;
        line_report_t got;
        line_report_t fresh;
        if (!rst_n)
        begin
            clear_line();
            predicted_reports.delete();
            reports_due <= 0;
        end
        else
        begin
            // check the outgoing item first: it cannot stem from this edge's input
            if (out_valid && !out_stall)
            begin
                got = '{kind, byte_value, byte_index, record_address, received_check,
                        computed_check, check_ok, bad_char};
                if (predicted_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected report: expected none, got %h", $time, got);
                end
                else
                begin
                    want = predicted_reports.pop_front();
                    check_field("kind", 16'(want.kind), 16'(got.kind));
                    check_field("byte_value", 16'(want.value), 16'(got.value));
                    check_field("byte_index", 16'(want.index), 16'(got.index));
                    check_field("record_address", want.address, got.address);
                    check_field("received_check", 16'(want.rx_sum), 16'(got.rx_sum));
                    check_field("computed_check", 16'(want.calc_sum), 16'(got.calc_sum));
                    check_field("check_ok", 16'(want.sum_ok), 16'(got.sum_ok));
                    check_field("bad_char", 16'(want.bad), 16'(got.bad));
                end
            end
            if (in_valid && !in_stall)
            begin
                if (parse_char(char_in, fresh))
                    predicted_reports.insert(predicted_reports.size(), fresh);
            end
            reports_due <= predicted_reports.size();
        end
        fail_count <= mismatches;
    end

endmodule

// ===== dv/hex_record_line_parser_top_tb.sv =====
// ----------------------------------------------------------------------------
// hex_record_line_parser_top_tb
// Feeds the hex record line parser with a few hand-written lines, then with
// random well-formed, broken and noise lines under three idling patterns
// and one long output hold-off. A checker beside the block does the
// prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module hex_record_line_parser_top_tb;
    import hrlp_pkg::*;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam int         HOLD_OFF_CYCLES = 80;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  char_in = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        kind;
    logic [7:0]  byte_value;
    logic [7:0]  byte_index;
    logic [15:0] record_address;
    logic [7:0]  received_check;
    logic [7:0]  computed_check;
    logic        check_ok;
    logic        bad_char;
    int          reports_due;
    int          fail_count;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_req = 0;
    int          chars_sent = 0;
    logic [7:0]  line_buf[$];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    hex_record_line_parser_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_in        (char_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .byte_value     (byte_value),
        .byte_index     (byte_index),
        .record_address (record_address),
        .received_check (received_check),
        .computed_check (computed_check),
        .check_ok       (check_ok),
        .bad_char       (bad_char)
    );

    hex_record_line_parser_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_in        (char_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .byte_value     (byte_value),
        .byte_index     (byte_index),
        .record_address (record_address),
        .received_check (received_check),
        .computed_check (computed_check),
        .check_ok       (check_ok),
        .bad_char       (bad_char),
        .reports_due    (reports_due),
        .fail_count     (fail_count)
    );

    // Receiver: random stalls, plus a long hold-off whenever one is requested
    initial
    begin
        int hold_left;
        int hold_done;
        hold_left = 0;
        hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_req != hold_done)
            begin
                hold_done = hold_req;
                hold_left = HOLD_OFF_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic offer_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (c != CH_CR)
            chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            offer_char(s[i]);
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            offer_char(line_buf[i]);
    endtask

    task automatic add_char(input logic [7:0] c);
        line_buf.insert(line_buf.size(), c);
    endtask

    task automatic push_hex(input logic [3:0] v);
        if (v < 4'd10)
            add_char(CH_ZERO + 8'(v));
        else
            add_char(CH_LA + 8'(v) - 8'd10);
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_hex(b[7:4]);
        push_hex(b[3:0]);
    endtask

    // Header, colon, data bytes, comma and checksum, with the usual variations
    task automatic make_record(input int nbytes);
        int         ndig;
        int         tail;
        logic [7:0] b;
        logic [7:0] sum;
        ndig = $urandom_range(0, 7);
        sum  = '0;
        if ($urandom_range(0, 3) == 0)
            add_char(CH_SKIP);
        for (int i = 0; i < ndig; i++)
        begin
            push_hex(4'($urandom_range(0, 15)));
            if ($urandom_range(0, 9) == 0)
                add_char(CH_SKIP);
        end
        if ($urandom_range(0, 19) != 0)
        begin
            add_char(CH_COLON);
            for (int i = 0; i < nbytes; i++)
            begin
                b   = 8'($urandom_range(0, 255));
                sum = sum ^ b;
                push_byte(b);
                if ($urandom_range(0, 15) == 0)
                    add_char(CH_CR);
            end
            tail = $urandom_range(0, 9);
            if (tail == 0)
                push_hex(4'($urandom_range(0, 15)));
            if (tail != 1)
            begin
                add_char(CH_COMMA);
                if (tail == 2)
                    push_hex(4'($urandom_range(0, 15)));
                else if (tail == 3)
                    push_byte(8'($urandom_range(0, 255)));
                else if (tail != 4)
                    push_byte(sum);
                if (tail == 5)
                    for (int i = $urandom_range(1, 3); i > 0; i--)
                        push_hex(4'($urandom_range(0, 15)));
            end
        end
        if ($urandom_range(0, 2) == 0)
            add_char(CH_CR);
        add_char(CH_LF);
    endtask

    task automatic random_line();
        int pick;
        int pos;
        line_buf.delete();
        pick = $urandom_range(0, 99);
        if (pick < 70)
            make_record($urandom_range(0, 12));
        else if (pick < 85)
        begin
            // record line with one character spoilt, sometimes a comma added, line feed kept
            make_record($urandom_range(0, 8));
            if (line_buf.size() > 1)
            begin
                pos = $urandom_range(0, line_buf.size() - 2);
                case ($urandom_range(0, 2))
                    0:       line_buf[pos] = CH_UPPER_A + 8'($urandom_range(0, 5));
                    1:       line_buf[pos] = ($urandom_range(0, 1) == 0) ? CH_COLON : CH_SKIP;
                    default: line_buf[pos] = 8'($urandom_range(0, 255));
                endcase
                if ($urandom_range(0, 3) == 0)
                    line_buf.insert(pos, CH_COMMA);
            end
        end
        else
        begin
            for (int i = $urandom_range(1, 12); i > 0; i--)
                add_char(8'($urandom_range(0, 255)));
            add_char(CH_LF);
        end
        send_line();
    endtask

    task automatic run_phase(input int target);
        while (chars_sent < target)
            random_line();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 37;
        recv_idle_pct = 53;

        // plain record with skipped H and full checksum
        send_text("H1f:00ff,ff");
        offer_char(CH_LF);
        // odd data digit joins the checksum, extra checksum digits
        send_text(":0,a9b");
        offer_char(CH_LF);
        // uppercase digit, then carriage return and colon while skipping
        send_text("8A");
        offer_char(CH_CR);
        send_text(":");
        offer_char(CH_LF);
        offer_char(CH_LF);

        run_phase(200);

        send_idle_pct = 53;
        recv_idle_pct = 37;
        run_phase(400);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req++;
        run_phase(600);

        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (fail_count == 0)
            $display("hex_record_line_parser_top regression: pass");
        else
            $display("hex_record_line_parser_top regression: fail");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("hex_record_line_parser_top regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/hrlp_pkg.sv
rtl/core/hex_record_line_parser_top.sv
dv/hex_record_line_parser_checker.sv
dv/hex_record_line_parser_top_tb.sv
